>>> src/i2cwr_pkg.sv
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer package
// Shared types and constants: phases, bus commands, opcodes, error codes
// and the word structures passed between the pipeline and the sequencer.
// ----------------------------------------------------------------------------
package i2cwr_pkg;

  // Transmit store depth and the width of a count that can reach it.
  localparam int BUFFER_DEPTH = 8;
  localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
  localparam int COUNT_W      = 4;

  // Address byte helpers: write direction clears bit 0, read sets it.
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_FLAG = 8'h01;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_EVENT = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_SEND_ADDR   = 4'd1,
    PH_SEND_DATA   = 4'd2,
    PH_AFTER_WRITE = 4'd3,
    PH_REP_START   = 4'd4,
    PH_RECV_ADDR   = 4'd5,
    PH_RECV_DATA   = 4'd6,
    PH_RECV_ACK    = 4'd7,
    PH_STOP        = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_WRITE     = 2'd1,
    ERR_LAST_BYTE = 2'd2,
    ERR_READ_ADDR = 2'd3
  } err_t;

  // One input word.
  typedef struct packed {
    logic [1:0]         op;
    logic [6:0]         slave_address;
    logic [COUNT_W-1:0] send_count;
    logic [COUNT_W-1:0] recv_count;
    logic [2:0]         tx_slot;
    logic [7:0]         tx_value;
    logic               ack_seen;
    logic [7:0]         bus_rx_byte;
  } item_t;

  // One result word.
  typedef struct packed {
    logic       accepted;
    logic [2:0] bus_command;
    logic [7:0] bus_tx_byte;
    logic       rx_valid;
    logic [2:0] rx_position;
    logic [7:0] rx_data;
    logic       busy_res;
    logic [1:0] error_code;
  } result_t;

  // Saturate a requested byte count to the store depth.
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] lim;
    lim = COUNT_W'(BUFFER_DEPTH);
    return (c > lim) ? lim : c;
  endfunction

  // Error code recorded for an unexpected NACK in a given phase.
  function automatic err_t nack_code(input phase_t ph);
    err_t e;
    if (ph == PH_AFTER_WRITE) begin
      e = ERR_LAST_BYTE;
    end else if (ph == PH_RECV_DATA || ph == PH_RECV_ADDR) begin
      e = ERR_READ_ADDR;
    end else begin
      e = ERR_WRITE;
    end
    return e;
  endfunction

endpackage

>>> src/i2cwr_ifs.sv
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------

// Input channel: opcodes, start parameters, loads and bus events.
interface i2cwr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] slave_address;
  logic [3:0] send_count;
  logic [3:0] recv_count;
  logic [2:0] tx_slot;
  logic [7:0] tx_value;
  logic       ack_seen;
  logic [7:0] bus_rx_byte;

  modport source (
    output valid, op, slave_address, send_count, recv_count, tx_slot, tx_value,
           ack_seen, bus_rx_byte,
    input  ready
  );
  modport sink (
    input  valid, op, slave_address, send_count, recv_count, tx_slot, tx_value,
           ack_seen, bus_rx_byte,
    output ready
  );
endinterface

// Result channel: bus command, received byte and status.
interface i2cwr_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] bus_command;
  logic [7:0] bus_tx_byte;
  logic       rx_valid;
  logic [2:0] rx_position;
  logic [7:0] rx_data;
  logic       busy_res;
  logic [1:0] error_code;

  modport source (
    output valid, accepted, bus_command, bus_tx_byte, rx_valid, rx_position,
           rx_data, busy_res, error_code,
    input  ready
  );
  modport sink (
    input  valid, accepted, bus_command, bus_tx_byte, rx_valid, rx_position,
           rx_data, busy_res, error_code,
    output ready
  );
endinterface

>>> src/i2cwr_seq.sv
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer core
// Holds the transaction state and transmit store, and turns one word into
// one result per step. State advances only when step_en is high.
// ----------------------------------------------------------------------------
module i2cwr_seq import i2cwr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t res
);

  phase_t             phase_r,      phase_nxt;
  logic               check_ack_r,  check_ack_nxt;
  logic [COUNT_W-1:0] byte_index_r, byte_index_nxt;
  logic [COUNT_W-1:0] send_total_r, send_total_nxt;
  logic [COUNT_W-1:0] recv_total_r, recv_total_nxt;
  logic [6:0]         target_r,     target_nxt;
  err_t               last_error_r, last_error_nxt;

  // Transmit store; contents are undefined until loaded.
  logic [7:0] tx_store_r [BUFFER_DEPTH];

  logic               store_we;
  logic [COUNT_W:0]   index_inc;
  logic [7:0]         store_byte;
  logic [7:0]         addr_byte;

  assign index_inc  = {1'b0, byte_index_r} + 1'b1;
  assign addr_byte  = {target_r, 1'b0};
  assign store_byte = (byte_index_r < COUNT_W'(BUFFER_DEPTH))
                      ? tx_store_r[byte_index_r[SLOT_W-1:0]] : 8'h00;

  // Next state and the result word for the current step.
  always_comb begin
    phase_nxt      = phase_r;
    check_ack_nxt  = check_ack_r;
    byte_index_nxt = byte_index_r;
    send_total_nxt = send_total_r;
    recv_total_nxt = recv_total_r;
    target_nxt     = target_r;
    last_error_nxt = last_error_r;
    store_we       = 1'b0;

    res.accepted    = 1'b0;
    res.bus_command = CMD_NONE;
    res.bus_tx_byte = 8'h00;
    res.rx_valid    = 1'b0;
    res.rx_position = 3'd0;
    res.rx_data     = 8'h00;

    case (op_t'(item.op))
      OP_LOAD: begin
        store_we = (phase_r == PH_IDLE);
      end
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          send_total_nxt  = clamp_count(item.send_count);
          recv_total_nxt  = clamp_count(item.recv_count);
          target_nxt      = item.slave_address;
          phase_nxt       = (clamp_count(item.send_count) != '0) ? PH_SEND_ADDR
                                                                 : PH_RECV_ADDR;
          last_error_nxt  = ERR_NONE;
          res.accepted    = 1'b1;
          res.bus_command = CMD_START;
        end
      end
      OP_EVENT: begin
        check_ack_nxt = 1'b0;
        if (check_ack_r && item.ack_seen) begin
          // Unexpected NACK: stop the bus and record the phase's error.
          last_error_nxt  = nack_code(phase_r);
          phase_nxt       = PH_STOP;
          res.bus_command = CMD_STOP;
        end else begin
          unique case (phase_r)
            PH_SEND_ADDR: begin
              res.bus_tx_byte = addr_byte & ADDR_WR_MASK;
              res.bus_command = CMD_WRITE;
              byte_index_nxt  = '0;
              phase_nxt       = PH_SEND_DATA;
              check_ack_nxt   = 1'b1;
            end
            PH_SEND_DATA: begin
              res.bus_tx_byte = store_byte;
              res.bus_command = CMD_WRITE;
              byte_index_nxt  = index_inc[COUNT_W-1:0];
              check_ack_nxt   = 1'b1;
              if (index_inc >= {1'b0, send_total_r}) begin
                phase_nxt = PH_AFTER_WRITE;
              end
            end
            PH_AFTER_WRITE: begin
              res.bus_command = CMD_STOP;
              phase_nxt       = (recv_total_r == '0) ? PH_STOP : PH_REP_START;
            end
            PH_REP_START: begin
              res.bus_command = CMD_START;
              phase_nxt       = PH_RECV_ADDR;
            end
            PH_RECV_ADDR: begin
              res.bus_tx_byte = addr_byte | ADDR_RD_FLAG;
              res.bus_command = CMD_WRITE;
              byte_index_nxt  = '0;
              check_ack_nxt   = 1'b1;
              phase_nxt       = PH_RECV_DATA;
            end
            PH_RECV_DATA: begin
              if (byte_index_r >= recv_total_r) begin
                res.bus_command = CMD_STOP;
                phase_nxt       = PH_IDLE;
              end else begin
                res.bus_command = CMD_RECV;
                phase_nxt       = PH_RECV_ACK;
              end
            end
            PH_RECV_ACK: begin
              // Deliver the byte; the last one is answered with a NACK.
              res.rx_valid    = 1'b1;
              res.rx_position = byte_index_r[2:0];
              res.rx_data     = item.bus_rx_byte;
              res.bus_command = (index_inc == {1'b0, recv_total_r}) ? CMD_NACK
                                                                    : CMD_ACK;
              byte_index_nxt  = index_inc[COUNT_W-1:0];
              phase_nxt       = PH_RECV_DATA;
            end
            PH_STOP: begin
              phase_nxt = PH_IDLE;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    res.busy_res   = (phase_nxt != PH_IDLE);
    res.error_code = last_error_nxt;
  end

  // Transaction state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      check_ack_r  <= 1'b1;
      byte_index_r <= '0;
      send_total_r <= '0;
      recv_total_r <= '0;
      target_r     <= '0;
      last_error_r <= ERR_NONE;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      check_ack_r  <= check_ack_nxt;
      byte_index_r <= byte_index_nxt;
      send_total_r <= send_total_nxt;
      recv_total_r <= recv_total_nxt;
      target_r     <= target_nxt;
      last_error_r <= last_error_nxt;
    end
  end

  // Transmit store writes, only while idle.
  always_ff @(posedge clk) begin
    if (step_en && store_we) begin
      tx_store_r[item.tx_slot[SLOT_W-1:0]] <= item.tx_value;
    end
  end

endmodule

>>> src/i2c_write_then_read_sequencer_top.sv
// Path: an accepted input word is held in the input word register; its result
// word is then captured in the result register that drives the result port.
// Throughput: one word per cycle unless the result port stalls.
// Reset (synchronous, active low) returns the sequencer to idle with the
// acknowledge check armed; the transmit store is undefined until loaded.
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer top level
// Input word register, sequencer step and result register with flow control.
// ----------------------------------------------------------------------------
module i2c_write_then_read_sequencer_top import i2cwr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  i2cwr_in_if.sink    in_ch,
  i2cwr_out_if.source out_ch
);

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t step_res;
  logic    advance;

  // The registered word moves on when the result register is free or draining.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Input word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= '{op:            in_ch.op,
                     slave_address: in_ch.slave_address,
                     send_count:    in_ch.send_count,
                     recv_count:    in_ch.recv_count,
                     tx_slot:       in_ch.tx_slot,
                     tx_value:      in_ch.tx_value,
                     ack_seen:      in_ch.ack_seen,
                     bus_rx_byte:   in_ch.bus_rx_byte};
    end
  end

  i2cwr_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .res     (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_res_r.accepted;
  assign out_ch.bus_command = out_res_r.bus_command;
  assign out_ch.bus_tx_byte = out_res_r.bus_tx_byte;
  assign out_ch.rx_valid    = out_res_r.rx_valid;
  assign out_ch.rx_position = out_res_r.rx_position;
  assign out_ch.rx_data     = out_res_r.rx_data;
  assign out_ch.busy_res    = out_res_r.busy_res;
  assign out_ch.error_code  = out_res_r.error_code;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer testbench
// Drives load, start and bus event words into the sequencer with random gaps
// on both channels. An in-bench copy of the sequencer predicts every result
// word, and each arriving word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cwr_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 28;
  localparam int NACK_PCT    = 4;

  logic clk;
  logic rst_n;

  i2cwr_in_if  in_if ();
  i2cwr_out_if out_if ();

  i2c_write_then_read_sequencer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Expected result words, oldest first.
  result_t expected_results[$];

  // Copy of the sequencer state used for prediction.
  phase_t     seq_phase;
  logic       seq_check_ack;
  logic [3:0] seq_index;
  logic [3:0] seq_send;
  logic [3:0] seq_recv;
  logic [6:0] seq_addr;
  err_t       seq_error;
  logic [7:0] tx_copy [BUFFER_DEPTH];

  int  mismatches;
  int  items_sent;
  int  stall_cycles;
  int  hold_request;
  int  hold_left;
  bit  tx_steady;
  bit  rx_steady;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a requested byte count to the store depth.
  function automatic logic [3:0] saturate(input logic [3:0] c);
    return (c > 4'(BUFFER_DEPTH)) ? 4'(BUFFER_DEPTH) : c;
  endfunction

  // Advance the sequencer copy by one accepted word and return its result.
  function automatic result_t sequencer_step(input item_t w);
    result_t r;
    logic    stopped;
    r = '0;
    stopped = 1'b0;
    case (op_t'(w.op))
      OP_LOAD: begin
        if (seq_phase == PH_IDLE && int'(w.tx_slot) < BUFFER_DEPTH) begin
          tx_copy[w.tx_slot] = w.tx_value;
        end
      end
      OP_START: begin
        if (seq_phase == PH_IDLE) begin
          seq_send  = saturate(w.send_count);
          seq_recv  = saturate(w.recv_count);
          seq_addr  = w.slave_address;
          seq_phase = (seq_send != 4'd0) ? PH_SEND_ADDR : PH_RECV_ADDR;
          seq_error = ERR_NONE;
          r.accepted    = 1'b1;
          r.bus_command = CMD_START;
        end
      end
      OP_EVENT: begin
        // A NACK where an acknowledge is due stops the bus.
        if (seq_check_ack) begin
          seq_check_ack = 1'b0;
          if (w.ack_seen) begin
            if (seq_phase == PH_AFTER_WRITE) begin
              seq_error = ERR_LAST_BYTE;
            end else if (seq_phase == PH_RECV_DATA || seq_phase == PH_RECV_ADDR) begin
              seq_error = ERR_READ_ADDR;
            end else begin
              seq_error = ERR_WRITE;
            end
            seq_phase     = PH_STOP;
            r.bus_command = CMD_STOP;
            stopped       = 1'b1;
          end
        end
        if (!stopped) begin
          case (seq_phase)
            PH_SEND_ADDR: begin
              r.bus_tx_byte = {seq_addr, 1'b0};
              r.bus_command = CMD_WRITE;
              seq_index     = 4'd0;
              seq_phase     = PH_SEND_DATA;
              seq_check_ack = 1'b1;
            end
            PH_SEND_DATA: begin
              r.bus_tx_byte = (seq_index < 4'(BUFFER_DEPTH)) ? tx_copy[seq_index[2:0]] : 8'd0;
              r.bus_command = CMD_WRITE;
              seq_index     = seq_index + 4'd1;
              seq_check_ack = 1'b1;
              if (seq_index >= seq_send) seq_phase = PH_AFTER_WRITE;
            end
            PH_AFTER_WRITE: begin
              r.bus_command = CMD_STOP;
              seq_phase     = (seq_recv == 4'd0) ? PH_STOP : PH_REP_START;
            end
            PH_REP_START: begin
              r.bus_command = CMD_START;
              seq_phase     = PH_RECV_ADDR;
            end
            PH_RECV_ADDR: begin
              r.bus_tx_byte = {seq_addr, 1'b1};
              r.bus_command = CMD_WRITE;
              seq_index     = 4'd0;
              seq_check_ack = 1'b1;
              seq_phase     = PH_RECV_DATA;
            end
            PH_RECV_DATA: begin
              if (seq_index >= seq_recv) begin
                r.bus_command = CMD_STOP;
                seq_phase     = PH_IDLE;
              end else begin
                r.bus_command = CMD_RECV;
                seq_phase     = PH_RECV_ACK;
              end
            end
            PH_RECV_ACK: begin
              r.rx_valid    = 1'b1;
              r.rx_position = seq_index[2:0];
              r.rx_data     = w.bus_rx_byte;
              r.bus_command = (seq_index + 4'd1 == seq_recv) ? CMD_NACK : CMD_ACK;
              seq_index     = seq_index + 4'd1;
              seq_phase     = PH_RECV_DATA;
            end
            PH_STOP: begin
              seq_phase = PH_IDLE;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    r.busy_res   = (seq_phase != PH_IDLE);
    r.error_code = seq_error;
    return r;
  endfunction

  // Report one field that differs from its expectation.
  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
    end
  endtask

  // Compare arriving result words and predict accepted input words.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    item_t   w;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.accepted, out_if.bus_command, out_if.bus_tx_byte,
                out_if.rx_valid, out_if.rx_position, out_if.rx_data,
                out_if.busy_res, out_if.error_code};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result word with none expected: %p", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("bus_command", want.bus_command, got.bus_command);
          check_field("bus_tx_byte", want.bus_tx_byte, got.bus_tx_byte);
          check_field("rx_valid", want.rx_valid, got.rx_valid);
          check_field("rx_position", want.rx_position, got.rx_position);
          check_field("rx_data", want.rx_data, got.rx_data);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
      if (in_if.valid && in_if.ready) begin
        w = '{in_if.op, in_if.slave_address, in_if.send_count, in_if.recv_count,
              in_if.tx_slot, in_if.tx_value, in_if.ack_seen, in_if.bus_rx_byte};
        expected_results.push_back(sequencer_step(w));
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_if.ready = 1'b0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(99) < IDLE_PCT) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // A word with every field random.
  function automatic item_t random_word();
    item_t w;
    w.op            = 2'($urandom_range(0, 3));
    w.slave_address = 7'($urandom);
    w.send_count    = 4'($urandom);
    w.recv_count    = 4'($urandom);
    w.tx_slot       = 3'($urandom);
    w.tx_value      = 8'($urandom);
    w.ack_seen      = 1'($urandom);
    w.bus_rx_byte   = 8'($urandom);
    return w;
  endfunction

  function automatic item_t word_of(input op_t op);
    item_t w;
    w = random_word();
    w.op = op;
    return w;
  endfunction

  function automatic item_t event_word(input logic nack, input logic [7:0] rx);
    item_t w;
    w = word_of(OP_EVENT);
    w.ack_seen    = nack;
    w.bus_rx_byte = rx;
    return w;
  endfunction

  // Mostly in-range counts, now and then one that saturates.
  function automatic logic [3:0] pick_count();
    return ($urandom_range(99) < 15) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
  endfunction

  // Offer one word at the falling edge and hold it until it is taken.
  // Each cycle idles at random, so the sender is idle about IDLE_PCT of the time.
  task automatic send_word(input item_t w);
    @(negedge clk);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.op            <= w.op;
    in_if.slave_address <= w.slave_address;
    in_if.send_count    <= w.send_count;
    in_if.recv_count    <= w.recv_count;
    in_if.tx_slot       <= w.tx_slot;
    in_if.tx_value      <= w.tx_value;
    in_if.ack_seen      <= w.ack_seen;
    in_if.bus_rx_byte   <= w.bus_rx_byte;
    in_if.valid         <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // One start request followed by enough bus events to finish it, with the
  // odd stray word and NACK mixed in.
  task automatic run_transaction(input int nack_pct);
    item_t w;
    int    s;
    int    m;
    int    events;
    w = word_of(OP_START);
    w.send_count = pick_count();
    w.recv_count = pick_count();
    s = saturate(w.send_count);
    m = saturate(w.recv_count);
    events = (s > 0) ? s + 3 + ((m > 0) ? 2 + 2 * m : 0) : 2 + 2 * m;
    events += $urandom_range(0, 1);
    send_word(w);
    repeat (events) begin
      if ($urandom_range(99) < 6) send_word(random_word());
      send_word(event_word($urandom_range(99) < nack_pct, 8'($urandom)));
    end
  endtask

  // The first event after reset finds the acknowledge check armed while idle.
  task automatic test_nack_while_idle();
    send_word(event_word(1'b1, 8'h00));
    send_word(event_word(1'b0, 8'hFF));
  endtask

  // Fill every slot of the transmit store, extremes included.
  task automatic test_store_load();
    item_t w;
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      w = word_of(OP_LOAD);
      w.tx_slot  = 3'(i);
      w.tx_value = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
      send_word(w);
    end
  endtask

  // Full write-then-read with a load and a start offered while busy.
  task automatic test_write_then_read();
    item_t w;
    w = word_of(OP_START);
    w.slave_address = 7'h7F;
    w.send_count    = 4'd1;
    w.recv_count    = 4'd2;
    send_word(w);
    send_word(event_word(1'b0, 8'($urandom)));
    send_word(word_of(OP_LOAD));
    send_word(word_of(OP_START));
    for (int i = 0; i < 9; i++) begin
      send_word(event_word(1'b0, (i == 5) ? 8'hFF : (i == 7) ? 8'h00 : 8'($urandom)));
    end
  endtask

  // Unused opcode, then an empty transaction to address zero.
  task automatic test_unused_op_and_empty();
    item_t w;
    send_word(word_of(OP_NOP));
    w = word_of(OP_START);
    w.slave_address = 7'h00;
    w.send_count    = 4'd0;
    w.recv_count    = 4'd0;
    send_word(w);
    send_word(event_word(1'b0, 8'($urandom)));
    send_word(event_word(1'b0, 8'($urandom)));
  endtask

  // Result side holds off while the sender keeps offering words.
  task automatic test_receiver_hold();
    tx_steady = 1'b1;
    hold_request = 80;
    run_transaction(0);
    run_transaction(0);
    tx_steady = 1'b0;
  endtask

  // Sender pauses until the sequencer has answered everything.
  task automatic test_sender_drain();
    run_transaction(NACK_PCT);
    wait_for_results();
    run_transaction(NACK_PCT);
  endtask

  // A stretch with no gaps on either side.
  task automatic test_steady_stream();
    int stop_at;
    stop_at = items_sent + 200;
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    while (items_sent < stop_at) run_transaction(NACK_PCT);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET) run_transaction(NACK_PCT);
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD;
    in_if.slave_address = '0;
    in_if.send_count = '0;
    in_if.recv_count = '0;
    in_if.tx_slot = '0;
    in_if.tx_value = '0;
    in_if.ack_seen = 1'b0;
    in_if.bus_rx_byte = '0;
    seq_phase = PH_IDLE;
    seq_check_ack = 1'b1;
    seq_index = '0;
    seq_send = '0;
    seq_recv = '0;
    seq_addr = '0;
    seq_error = ERR_NONE;
    mismatches = 0;
    items_sent = 0;
    stall_cycles = 0;
    hold_request = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_nack_while_idle();
    test_store_load();
    test_write_then_read();
    test_unused_op_and_empty();
    test_receiver_hold();
    test_sender_drain();
    test_steady_stream();
    test_random_traffic();

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
